/* hw/rtl/crc16x_pkg.sv */
package crc16x_pkg;

   // Reflected CCITT polynomial and per-message seed
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Fold one byte into the running CRC, least significant bit first
   function automatic logic [15:0] fold_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data_in);
      logic [15:0] crc;
      logic [7:0]  dat;
      crc = crc_in;
      dat = data_in;
      for (int k = 0; k < 8; k++) begin
         if (crc[0] ^ dat[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
         dat = dat >> 1;
      end
      return crc;
   endfunction

endpackage

/* hw/rtl/crc16x_fold.sv */
module crc16x_fold
   import crc16x_pkg::*;
(
   input  logic [15:0] crc_cur,
   input  logic [7:0]  data_byte,
   input  logic        last,
   output logic [15:0] crc_next,
   output logic [15:0] crc_value
);

   logic [15:0] folded;
   logic [15:0] inverted;

   // Unrolled eight-bit update
   assign folded = fold_byte(crc_cur, data_byte);

   // Reload the seed after the closing byte of a message
   assign crc_next = last ? CRC_INIT : folded;

   // Invert and swap bytes for the final value
   assign inverted  = ~folded;
   assign crc_value = {inverted[7:0], inverted[15:8]};

endmodule

/* hw/rtl/crc16_reflected_byte_stream_core.sv */
// Reflected CRC-16 (X.25 style, polynomial 0x8408, seed 0xFFFF) over a byte
// stream. Each req beat carries one message byte, taken least significant bit
// first; a beat with req_last set closes the message and yields one rsp beat
// holding the inverted CRC with its two bytes swapped, after which the CRC
// reloads 0xFFFF. Throughput is one byte per cycle unless a closing byte waits
// on a full result slot; the eight-bit update is one unrolled step between the
// input register and the CRC register. A closing byte reaches its rsp beat via
// the input register, then the result register; other bytes produce none.
module crc16_reflected_byte_stream_core
   import crc16x_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_crc_value
);

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_data_ff;
   logic        s1_last_ff;
   logic [15:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_crc_value_ff;

   logic        s1_adv;
   logic        out_free;
   logic [15:0] crc_next;
   logic [15:0] crc_value;

   // Result slot can take a new value when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Advance the input stage; a closing byte needs a free result slot
   assign s1_adv    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_adv;

   crc16x_fold u_fold (
      .crc_cur   (crc_ff),
      .data_byte (s1_data_ff),
      .last      (s1_last_ff),
      .crc_next  (crc_next),
      .crc_value (crc_value)
   );

   // Next-state logic for the control registers
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      crc_in = crc_ff;
      if (s1_adv) begin
         crc_in = crc_next;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_adv && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the input beat
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last;
      end
   end

   // Load the result register on a closing byte
   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         rsp_crc_value_ff <= crc_value;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_value_ff;

   // Closing byte reloads the seed
   a_seed_reload: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (crc_ff == CRC_INIT))
      else $error("CRC not reloaded after closing byte");

   // Closing byte always produces a result beat
   a_result_issued: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> rsp_valid_ff)
      else $error("closing byte gave no result");

   // A result beat appears only from a closing byte
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_adv && s1_last_ff))
      else $error("result beat without closing byte");

   // Stalled closing byte blocks the input side and holds the CRC
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready)
         |-> (!req_ready && (crc_in == crc_ff)))
      else $error("closing byte advanced into a full result slot");

endmodule

/* tb/crc16_reflected_byte_stream_core_tb.sv */
module crc16_reflected_byte_stream_core_tb;

   localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
   localparam logic [15:0] CRC_SEED      = 16'hFFFF;
   localparam int          STALL_LIMIT   = 1000;
   localparam int          HOLD_CYCLES   = 80;
   localparam int          HOLD_AT_RSP   = 40;
   localparam int          RANDOM_ITEMS  = 1300;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       drain;   // wait for all CRCs to come back before offering
   } byte_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_crc_value;

   byte_beat_type byte_q[$];
   logic [15:0] crc_expect_q[$];
   logic [15:0] crc_state;
   bit          failed = 1'b0;
   int          rsp_count = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          stall_cycles = 0;

   crc16_reflected_byte_stream_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_crc_value (rsp_crc_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Fold one byte into the running CRC, LSB first
   function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
      return r;
   endfunction

   // No random idling on either side inside this window
   function automatic bit quiet_window();
      return ($time >= 6000) && ($time < 10000);
   endfunction

   function automatic void add_byte(input logic [7:0] data, input logic last,
                                    input logic drain = 1'b0);
      byte_beat_type b;
      b.data  = data;
      b.last  = last;
      b.drain = drain;
      byte_q.push_back(b);
   endfunction

   task automatic add_random_message(input int len, output int added);
      for (int i = 0; i < len; i++) begin
         add_byte(8'($urandom_range(255)), i == len - 1);
      end
      added = len;
   endtask

   // Driver: present queued beats, predict CRC on each accepted beat
   always @(posedge clock) begin
      byte_beat_type nxt;
      logic [15:0] inv;
      if (reset) begin
         req_valid <= 1'b0;
         crc_state = CRC_SEED;
      end else begin
         if (req_valid && req_ready) begin
            crc_state = crc_fold(crc_state, req_data_byte);
            if (req_last) begin
               inv = ~crc_state;
               crc_expect_q.push_back({inv[7:0], inv[15:8]});
               crc_state = CRC_SEED;
            end
         end
         if (!(req_valid && !req_ready)) begin
            if (byte_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (byte_q[0].drain && crc_expect_q.size() != 0) begin
               req_valid <= 1'b0;
            end else if (!quiet_window() && $urandom_range(99) < 34) begin
               req_valid <= 1'b0;
            end else begin
               nxt = byte_q.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= nxt.data;
               req_last      <= nxt.last;
            end
         end
      end
   end

   // Monitor: compare each CRC beat, drive rsp_ready with random stalls and one long stall
   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (crc_expect_q.size() == 0) begin
               $display("%0t: unexpected crc_value beat, expected none, got %h",
                        $time, rsp_crc_value);
               failed = 1'b1;
            end else begin
               want = crc_expect_q.pop_front();
               if (rsp_crc_value !== want) begin
                  $display("%0t: crc_value mismatch, expected %h, got %h",
                           $time, want, rsp_crc_value);
                  failed = 1'b1;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && rsp_count >= HOLD_AT_RSP) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_window() || ($urandom_range(99) >= 34);
         end
      end
   end

   // Watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      int total;
      int n;
      int len;
      logic [7:0] check_str[9];

      // Directed: single-byte extremes
      add_byte(8'h00, 1'b1);
      add_byte(8'hFF, 1'b1);
      add_byte(8'h01, 1'b1);
      add_byte(8'h80, 1'b1);
      // Standard check string "123456789"
      check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
      foreach (check_str[i]) add_byte(check_str[i], i == 8);
      // All-ones and all-zeros runs, alternating bits
      for (int i = 0; i < 4; i++) add_byte(8'hFF, i == 3);
      for (int i = 0; i < 3; i++) add_byte(8'h00, i == 2);
      add_byte(8'h55, 1'b0);
      add_byte(8'hAA, 1'b1);

      // Random messages, mostly short, some long
      total = 0;
      while (total < RANDOM_ITEMS) begin
         if (total >= RANDOM_ITEMS / 2 && total < RANDOM_ITEMS / 2 + 8) begin
            add_byte(8'($urandom_range(255)), 1'b1, 1'b1);
            total += 1;
         end
         if ($urandom_range(9) == 0) len = $urandom_range(40, 9);
         else len = $urandom_range(4, 1);
         add_random_message(len, n);
         total += n;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Hold until stimulus is accepted and all CRCs have come back
      do @(negedge clock); while (byte_q.size() != 0 || req_valid);
      while (crc_expect_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      if (!failed) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
